>>> hw/rtl/mict_pkg.sv
// shared types and constants for the multiset intersection count table
// no dependencies
package mict_pkg;

  // table_slots: number of hash slots; count_bits: width of each slot's count
  localparam int TABLE_SLOTS = 1024;
  localparam int COUNT_BITS  = 16;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_PROBE  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } slot_t;

endpackage

>>> hw/rtl/multiset_intersection_count_table.sv
// load/probe: word accepted in idle, then each probed slot is read and checked
//   (linear probing over one synchronous table ram), result registered on the out side
// one word at a time: no new word is taken until the last result is registered;
//   an unused request type goes straight to the result; clear sweeps one ram row per cycle
// reset (rst_n low, synchronous): the same clearing sweep runs with in_tready low;
//   no result word is produced for it
module multiset_intersection_count_table
  import mict_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic signed [KEY_BITS-1:0] in_tdata,   // [31:0] key
  input  logic [1:0]                 in_tuser,   // [1:0] req_type
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic signed [KEY_BITS-1:0] out_tdata,  // [31:0] key_out
  output logic [1:0]                 out_tuser   // [0] matched, [1] status
);

  localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  slot_t tbl_mem [TABLE_SLOTS];
  slot_t rdata_r;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    step_r, step_nxt;
  logic                clr_resp_r, clr_resp_nxt;
  req_t                req_r, req_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;

  logic                out_tvalid_r, out_tvalid_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;
  logic                out_matched_r, out_matched_nxt;
  logic                out_status_r, out_status_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;
  logic             out_free;
  logic             in_fire;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // table ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= tbl_mem[idx_r];
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    step_nxt        = step_r;
    clr_resp_nxt    = clr_resp_r;
    req_nxt         = req_r;
    key_nxt         = key_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_key_nxt     = out_key_r;
    out_matched_nxt = out_matched_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    mem_wdata       = rdata_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_wdata       = '0;
        if (idx_r != IDX_LAST) begin
          idx_nxt = idx_r + IDX_W'(1);
        end else if (!clr_resp_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          // sweep done, hand back the clear word
          state_nxt       = ST_IDLE;
          out_tvalid_nxt  = 1'b1;
          out_key_nxt     = key_r;
          out_matched_nxt = 1'b0;
          out_status_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt  = req_t'(in_tuser);
          key_nxt  = in_tdata;
          idx_nxt  = IDX_W'({1'b0, in_tdata} % TABLE_SLOTS);
          step_nxt = '0;
          unique case (req_t'(in_tuser))
            REQ_LOAD, REQ_PROBE: state_nxt = ST_READ;
            REQ_CLEAR: begin
              state_nxt    = ST_CLEAR;
              clr_resp_nxt = 1'b1;
              idx_nxt      = '0;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (rdata_r.valid && rdata_r.key != key_r && step_r != IDX_LAST) begin
          // collision, move on to the next slot
          state_nxt = ST_READ;
          step_nxt  = step_r + IDX_W'(1);
          idx_nxt   = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
        end else if (out_free) begin
          state_nxt       = ST_IDLE;
          out_tvalid_nxt  = 1'b1;
          out_key_nxt     = key_r;
          out_matched_nxt = 1'b0;
          out_status_nxt  = 1'b0;
          priority if (!rdata_r.valid) begin
            if (req_r == REQ_LOAD) begin
              mem_we          = 1'b1;
              mem_wdata.valid = 1'b1;
              mem_wdata.key   = key_r;
              mem_wdata.count = COUNT_BITS'(1);
            end
          end else if (rdata_r.key == key_r) begin
            if (req_r == REQ_LOAD) begin
              if (rdata_r.count != COUNT_MAX) begin
                mem_we          = 1'b1;
                mem_wdata.count = rdata_r.count + COUNT_BITS'(1);
              end
            end else if (rdata_r.count != '0) begin
              mem_we          = 1'b1;
              mem_wdata.count = rdata_r.count - COUNT_BITS'(1);
              out_matched_nxt = 1'b1;
            end
          end else begin
            // walked the whole table without a hole
            out_status_nxt = (req_r == REQ_LOAD);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt       = ST_IDLE;
          out_tvalid_nxt  = 1'b1;
          out_key_nxt     = key_r;
          out_matched_nxt = 1'b0;
          out_status_nxt  = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      idx_r        <= '0;
      clr_resp_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      clr_resp_r   <= clr_resp_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    req_r         <= req_nxt;
    key_r         <= key_nxt;
    out_key_r     <= out_key_nxt;
    out_matched_r <= out_matched_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_key_r;
  assign out_tuser  = {out_status_r, out_matched_r};

  // reset always starts a sweep, so no word is taken right after it
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input accepted right after reset");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_matched_r && out_status_r))
    else $error("matched and status both set");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_CHECK || $past(state_r) == ST_CLEAR ||
                             $past(state_r) == ST_DONE))
    else $error("result word raised outside a finishing state");

  a_write_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && mem_we) |-> out_free)
    else $error("table updated while result slot is busy");

endmodule
